FILE: hdl/hmq_pkg.sv
// shared types and constants for the binary max-heap priority queue
`default_nettype none

package hmq_pkg;

  // field widths
  localparam int KEY_BITS   = 32;
  localparam int COORD_BITS = 7;
  localparam int OCC_BITS   = 11;

  // default number of heap slots
  localparam int CAPACITY = 1024;

  // operation codes
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // one command transfer
  typedef struct packed {
    kind_t                        kind;
    logic signed [KEY_BITS-1:0]   key;
    logic        [COORD_BITS-1:0] row;
    logic        [COORD_BITS-1:0] col;
  } req_t;

  // one result transfer
  typedef struct packed {
    status_t                      status;
    logic signed [KEY_BITS-1:0]   top_key;
    logic        [COORD_BITS-1:0] top_row;
    logic        [COORD_BITS-1:0] top_col;
    logic        [OCC_BITS-1:0]   occupancy;
  } rsp_t;

  // one stored heap slot
  typedef struct packed {
    logic signed [KEY_BITS-1:0]   key;
    logic        [COORD_BITS-1:0] row;
    logic        [COORD_BITS-1:0] col;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/binary_max_heap_queue_unit.sv
// binary max-heap priority queue: sequencer around one key comparator and the slot memory
`default_nettype none

// Binary max-heap priority queue. A command transfer is taken when start is high and
// busy is low; for an accepted command busy then stays high until the result is issued,
// and the result is shown for exactly one cycle with done high, in the same cycle in
// which busy drops, so the next command may be given at once. The receiver cannot stall:
// results must be taken when done is high. An insert climbs from the new last slot,
// reading and comparing one parent per level; a pop reads the root and the last entry,
// then descends, reading and comparing the children of one level at a time. A pop on an
// empty heap or an insert into a full heap is answered with an error status, and busy
// does not go high for it. The step sequence is set by the single read port of the slot
// memory, whose read data are registered, and by the one key comparator used once per
// memory read. The slot memory needs no clearing after reset: only slots below the fill
// count are ever read.
module binary_max_heap_queue_unit #(
  parameter int CAPACITY = hmq_pkg::CAPACITY
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire hmq_pkg::req_t request,
  output logic        done,
  output hmq_pkg::rsp_t result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    IDLE,
    UP_RD,
    UP_CMP,
    POP_ROOT,
    POP_LAST,
    DN_L,
    DN_R,
    DN_CMP
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   pos;
  hmq_pkg::entry_t mov;
  hmq_pkg::entry_t top;
  hmq_pkg::entry_t best;
  logic            best_child;
  logic [CW-1:0]   best_pos;

  // memory ports
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  hmq_pkg::entry_t wr_data;
  logic [AW-1:0]   rd_addr;
  hmq_pkg::entry_t rd_data;

  // shared comparator
  logic signed [hmq_pkg::KEY_BITS-1:0] cmp_a;
  logic signed [hmq_pkg::KEY_BITS-1:0] cmp_b;
  logic                                gt;

  // decisions
  logic [CW:0]     left;
  logic [CW:0]     right;
  logic [CW:0]     cnt_ext;
  logic            finish;
  logic            reject;
  logic            move_child;
  hmq_pkg::entry_t child_ent;
  logic [CW-1:0]   child_pos;

  // slot address of a heap position (positions count from one)
  function automatic logic [AW-1:0] addr_of(input logic [CW:0] p);
    logic [CW:0] a;
    a = p - 1'b1;
    return a[AW-1:0];
  endfunction

  hmq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign left    = {pos, 1'b0};
  assign right   = left + 1'b1;
  assign cnt_ext = {1'b0, count};
  assign busy    = (state != IDLE);

  // command refused at once: pop on empty or insert into full
  assign reject = (state == IDLE) && start &&
                  ((request.kind == hmq_pkg::KIND_POP) ? (count == '0)
                                                        : (count == CW'(CAPACITY)));

  // comparator operand select
  always_comb begin
    cmp_a = rd_data.key;
    cmp_b = mov.key;
    unique case (state)
      UP_CMP: begin
        cmp_a = mov.key;
        cmp_b = rd_data.key;
      end
      DN_CMP: begin
        cmp_b = best.key;
      end
      default: begin
      end
    endcase
  end

  assign gt = (cmp_a > cmp_b);

  // memory addressing and move decisions
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = addr_of({1'b0, pos});
    wr_data    = mov;
    rd_addr    = '0;
    finish     = 1'b0;
    move_child = 1'b0;
    child_ent  = rd_data;
    child_pos  = left[CW-1:0];
    unique case (state)
      IDLE: begin
      end
      UP_RD: begin
        if (pos > CW'(1)) begin
          rd_addr = addr_of({1'b0, pos >> 1});
        end else begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end
      end
      UP_CMP: begin
        wr_en = 1'b1;
        if (gt) begin
          wr_data = rd_data;
        end else begin
          finish = 1'b1;
        end
      end
      POP_ROOT: begin
        rd_addr = addr_of(cnt_ext);
      end
      POP_LAST: begin
      end
      DN_L: begin
        if (left > cnt_ext) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rd_addr = addr_of(left);
        end
      end
      DN_R: begin
        if (right > cnt_ext) begin
          move_child = gt;
        end else begin
          rd_addr = addr_of(right);
        end
      end
      DN_CMP: begin
        if (gt) begin
          move_child = 1'b1;
          child_pos  = right[CW-1:0];
        end else if (best_child) begin
          move_child = 1'b1;
          child_ent  = best;
          child_pos  = best_pos;
        end
      end
      default: begin
      end
    endcase
    // sift-down settles either by moving the winning child up or by placing the entry
    if ((state == DN_CMP) || ((state == DN_R) && (right > cnt_ext))) begin
      wr_en = 1'b1;
      if (move_child) begin
        wr_data = child_ent;
      end else begin
        finish = 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= finish || reject;
      unique case (state)
        IDLE: begin
          if (start) begin
            if (request.kind == hmq_pkg::KIND_POP) begin
              if (count == '0) begin
                result <= '{status: hmq_pkg::STATUS_EMPTY, top_key: '0, top_row: '0,
                            top_col: '0, occupancy: hmq_pkg::OCC_BITS'(count)};
              end else begin
                state <= POP_ROOT;
              end
            end else begin
              if (count == CW'(CAPACITY)) begin
                result <= '{status: hmq_pkg::STATUS_FULL, top_key: '0, top_row: '0,
                            top_col: '0, occupancy: hmq_pkg::OCC_BITS'(count)};
              end else begin
                mov.key <= request.key;
                mov.row <= request.row;
                mov.col <= request.col;
                top     <= '0;
                count   <= count + 1'b1;
                pos     <= count + 1'b1;
                state   <= UP_RD;
              end
            end
          end
        end
        UP_RD: begin
          if (pos > CW'(1)) begin
            state <= UP_CMP;
          end
        end
        UP_CMP: begin
          if (gt) begin
            pos   <= pos >> 1;
            state <= UP_RD;
          end
        end
        POP_ROOT: begin
          top   <= rd_data;
          state <= POP_LAST;
        end
        POP_LAST: begin
          mov   <= rd_data;
          count <= count - 1'b1;
          pos   <= CW'(1);
          state <= DN_L;
        end
        DN_L: begin
          if (left <= cnt_ext) begin
            state <= DN_R;
          end
        end
        DN_R: begin
          best       <= gt ? rd_data : mov;
          best_child <= gt;
          best_pos   <= left[CW-1:0];
          if (right <= cnt_ext) begin
            state <= DN_CMP;
          end else if (move_child) begin
            pos   <= child_pos;
            state <= DN_L;
          end
        end
        DN_CMP: begin
          if (move_child) begin
            pos   <= child_pos;
            state <= DN_L;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      // result transfer once the moving entry has been placed
      if (finish) begin
        state  <= IDLE;
        result <= '{status: hmq_pkg::STATUS_OK, top_key: top.key, top_row: top.row,
                    top_col: top.col, occupancy: hmq_pkg::OCC_BITS'(count)};
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hmq_ram.sv
// heap slot storage: one write port, one registered read port
`default_nettype none

module hmq_ram #(
  parameter int DEPTH = hmq_pkg::CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [AW-1:0]  wr_addr,
  input  wire hmq_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]  rd_addr,
  output hmq_pkg::entry_t     rd_data
);

  hmq_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data arrive in the cycle after the address
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: tb/heap_queue_checker.sv
// checker for the heap queue: follows both channels, keeps its own heap and compares results
module heap_queue_checker
  import hmq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic done,
  input  rsp_t result,
  output int   mismatches,
  output int   owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow heap, 1-based like the hardware's tree numbering
  entry_t slots [1:CAPACITY];
  int     fill = 0;
  int     bad  = 0;
  rsp_t   heap_answers [$];

  function automatic void swap_slots(input int a, input int b);
    entry_t t;
    t        = slots[a];
    slots[a] = slots[b];
    slots[b] = t;
  endfunction

  // index of the largest of a node and its children, left child wins a tie
  function automatic int largest_of(input int pos);
    int left;
    int right;
    int best;
    left  = 2 * pos;
    right = left + 1;
    best  = pos;
    if (left <= fill && slots[left].key > slots[pos].key) best = left;
    if (right <= fill && slots[right].key > slots[best].key) best = right;
    return best;
  endfunction

  // apply one command to the shadow heap and return its answer
  function automatic rsp_t heap_apply(input req_t cmd);
    rsp_t r;
    int   pos;
    int   best;
    r        = '0;
    r.status = STATUS_OK;
    if (cmd.kind == KIND_INSERT) begin
      if (fill >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        fill++;
        slots[fill] = '{key: cmd.key, row: cmd.row, col: cmd.col};
        pos = fill;
        // climb while the parent is strictly smaller
        while (pos > 1 && slots[pos / 2].key < slots[pos].key) begin
          swap_slots(pos, pos / 2);
          pos = pos / 2;
        end
      end
    end else begin
      if (fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.top_key = slots[1].key;
        r.top_row = slots[1].row;
        r.top_col = slots[1].col;
        slots[1]  = slots[fill];
        fill--;
        // sink the moved entry until no child is strictly larger
        pos  = 1;
        best = largest_of(pos);
        while (best != pos) begin
          swap_slots(pos, best);
          pos  = best;
          best = largest_of(pos);
        end
      end
    end
    r.occupancy = fill[OCC_BITS-1:0];
    return r;
  endfunction

  // result check first, then the command taken at this edge
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fill = 0;
      heap_answers.delete();
    end else begin
      if (done) begin
        if (heap_answers.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("%0t: result with nothing outstanding: %p", $realtime, result);
        end else begin
          want = heap_answers.pop_front();
          if (want.status !== result.status || want.top_key !== result.top_key ||
              want.top_row !== result.top_row || want.top_col !== result.top_col ||
              want.occupancy !== result.occupancy) begin
            bad++;
            if (bad <= 10)
              $display({"%0t: mismatch (expected/actual) status %0d/%0d key %0d/%0d ",
                        "row %0d/%0d col %0d/%0d occupancy %0d/%0d"}, $realtime,
                       want.status, result.status, want.top_key, result.top_key,
                       want.top_row, result.top_row, want.top_col, result.top_col,
                       want.occupancy, result.occupancy);
          end
        end
      end
      if (start && !busy) heap_answers.push_back(heap_apply(request));
    end
    mismatches <= bad;
    owed       <= heap_answers.size();
  end

endmodule

FILE: tb/tb.sv
// top of the heap queue testbench: clock, reset, command stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hmq_pkg::*;

  localparam int LIMIT = 800000;

  logic clk     = 1'b0;
  logic rst     = 1'b1;
  logic start   = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;
  int   mismatches;
  int   owed;
  int   cycles  = 0;
  int   held    = 0;
  bit   calm    = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  binary_max_heap_queue_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  heap_queue_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .mismatches (mismatches),
    .owed       (owed)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // keys: many near-ties, the extremes, and full-range values
  function automatic logic signed [KEY_BITS-1:0] rand_key();
    case ($urandom_range(0, 9))
      0, 1, 2: return $signed($urandom_range(0, 15)) - 8;
      3: begin
        case ($urandom_range(0, 3))
          0: return {1'b0, {(KEY_BITS-1){1'b1}}};
          1: return {1'b1, {(KEY_BITS-1){1'b0}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_cmd(input int insert_pct);
    req_t r;
    r.kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_POP;
    r.key  = rand_key();
    r.row  = COORD_BITS'($urandom_range(0, 127));
    r.col  = COORD_BITS'($urandom_range(0, 127));
    return r;
  endfunction

  function automatic req_t fixed_cmd(input kind_t k, input logic signed [KEY_BITS-1:0] key,
                                     input int row, input int col);
    req_t r;
    r.kind = k;
    r.key  = key;
    r.row  = COORD_BITS'(row);
    r.col  = COORD_BITS'(col);
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // one command transfer; entered and left at a falling edge
  task automatic issue(input req_t cmd);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      start   <= 1'b0;
      request <= rand_cmd(50);
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= cmd;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (cmd.kind == KIND_INSERT && held < CAPACITY) held++;
    else if (cmd.kind == KIND_POP && held > 0) held--;
    // switch now and then between gapped and back-to-back stretches
    if ($urandom_range(0, 39) == 0) calm = !calm;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // pop on empty, key extremes, payload extremes, equal keys
    issue(fixed_cmd(KIND_POP, rand_key(), 127, 127));
    issue(fixed_cmd(KIND_INSERT, {1'b0, {(KEY_BITS-1){1'b1}}}, 127, 127));
    issue(fixed_cmd(KIND_INSERT, {1'b1, {(KEY_BITS-1){1'b0}}}, 0, 0));
    issue(fixed_cmd(KIND_INSERT, 0, 1, 2));
    issue(fixed_cmd(KIND_INSERT, -1, 3, 4));
    for (int n = 0; n < 4; n++) issue(fixed_cmd(KIND_INSERT, 5, 10 + n, 100 + n));
    repeat (9) issue(fixed_cmd(KIND_POP, rand_key(), $urandom_range(0, 127),
                               $urandom_range(0, 127)));

    // fill to capacity, then inserts into a full heap
    while (held < CAPACITY) issue(rand_cmd(98));
    repeat (4) issue(fixed_cmd(KIND_INSERT, rand_key(), $urandom_range(0, 127),
                               $urandom_range(0, 127)));

    // mostly pops against a deep heap
    repeat (100) issue(rand_cmd(20));

    start <= 1'b0;
    while (owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
